>>> hw/rtl/ccram_pkg.sv
// Shared types and codes for the cheat code ROM address mapper.
// No dependencies; every other file of the block imports this package.
package ccram_pkg;

  // Memory map codes held in the map_mode register
  localparam logic [2:0] MAP_MMC    = 3'd0;
  localparam logic [2:0] MAP_HYBRID = 3'd1;
  localparam logic [2:0] MAP_COPLO  = 3'd2;
  localparam logic [2:0] MAP_LOROM  = 3'd3;
  localparam logic [2:0] MAP_HIROM  = 3'd4;

  // Configuration register indexes
  localparam logic REG_MAP_MODE = 1'b0;
  localparam logic REG_ROM_SIZE = 1'b1;

  localparam int CODE_W   = 32;
  localparam int OFFSET_W = 22;
  localparam int SIZE_W   = 25;
  localparam int BYTE_W   = 8;

  localparam logic [2:0]          MAP_MODE_RESET = MAP_LOROM;
  localparam logic [OFFSET_W-1:0] FULL_MASK      = 22'h3fffff;

  typedef struct packed {
    logic [2:0]          map_mode;
    logic [OFFSET_W-1:0] mirror_mask;
  } ccram_cfg_t;

  typedef struct packed {
    logic                is_wram;
    logic                rom_hit;
    logic [OFFSET_W-1:0] rom_offset;
    logic [BYTE_W-1:0]   patch_byte;
  } ccram_result_t;

endpackage

>>> hw/rtl/ccram_cfg_regs.sv
// Configuration registers: memory map select and ROM mirror mask.
// Depends on ccram_pkg.
module ccram_cfg_regs
  import ccram_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  output ccram_cfg_t        cfg
);

  logic [SIZE_W-1:0] size_minus_one;

  assign size_minus_one = cfg_data - SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_mode    <= MAP_MODE_RESET;
      cfg.mirror_mask <= FULL_MASK;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_MODE: cfg.map_mode <= cfg_data[2:0];
        REG_ROM_SIZE: begin
          // keep the mask, not the size: zero selects the full 4 MiB mirror
          if (cfg_data == '0) begin
            cfg.mirror_mask <= FULL_MASK;
          end else begin
            cfg.mirror_mask <= size_minus_one[OFFSET_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/ccram_decode.sv
// Combinational decode of one cheat code: work RAM test, bus to ROM offset
// translation per memory map, and mirror masking. Depends on ccram_pkg.
module ccram_decode
  import ccram_pkg::*;
(
  input  logic [CODE_W-1:0] code,
  input  ccram_cfg_t        cfg,
  output ccram_result_t     result
);

  logic [7:0]          bank;
  logic [15:0]         lo;
  logic                wram;
  logic                hit;
  logic [OFFSET_W-1:0] off;
  logic [OFFSET_W-1:0] lorom;
  logic [OFFSET_W-1:0] linear;

  assign bank   = code[31:24];
  assign lo     = code[23:8];
  assign lorom  = {bank[6:0], lo[14:0]};
  assign linear = {bank[5:0], lo};

  // banks 7E/7F, or a low page in a bank without bit 6
  assign wram = (bank[7:1] == 7'h3f) || (!bank[6] && (lo[15:13] == 3'b000));

  always_comb begin
    hit = 1'b0;
    off = '0;
    case (cfg.map_mode)
      MAP_MMC: begin
        if (bank[7:6] == 2'b11) begin
          hit = 1'b1;
          off = linear;
        end else if (!bank[6] && lo[15]) begin
          hit = 1'b1;
          off = {bank[7], bank[5], bank[4:0], lo[14:0]};
        end
      end
      MAP_HYBRID: begin
        if (bank[6]) begin
          hit = (bank[6:5] != 2'b11);
          off = linear;
        end else begin
          hit = (lo[15:13] != 3'b011);
          off = lorom;
        end
      end
      MAP_COPLO, MAP_LOROM: begin
        hit = lo[15];
        off = lorom;
      end
      MAP_HIROM: begin
        // 40..7D, C0..FF, or the upper half of a bank without bit 6
        hit = (bank[7:6] == 2'b11) || (bank inside {[8'h40:8'h7d]}) ||
              (!bank[6] && lo[15]);
        off = linear;
      end
      default: hit = 1'b0;
    endcase
  end

  assign result.is_wram    = wram;
  assign result.rom_hit    = !wram && hit;
  assign result.rom_offset = (!wram && hit) ? (off & cfg.mirror_mask) : '0;
  assign result.patch_byte = code[BYTE_W-1:0];

endmodule

>>> hw/rtl/cheat_code_rom_address_mapper.sv
// Top level of the cheat code ROM address mapper.
// Depends on ccram_pkg, ccram_cfg_regs and ccram_decode.

// Takes one 32-bit cheat code per word and returns one result word per code:
// a work RAM flag, a ROM hit flag, the masked ROM image offset and the patch
// byte. A new code is accepted every cycle while the input is not stalled;
// each code passes through the input register and then the result register,
// with the address decode between them. The input side stalls only while
// both registers are full and the output side is stalled. Configuration
// writes (map_mode at index 0, rom_size_bytes at index 1) take effect on the
// next cycle and are meant to be made while the block is empty; the ROM size
// is stored as its mirror mask.
module cheat_code_rom_address_mapper
  import ccram_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [SIZE_W-1:0]   cfg_data,
  // code input channel
  input  logic                code_valid,
  output logic                code_stall,
  input  logic [CODE_W-1:0]   code,
  // result output channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic                is_wram,
  output logic                rom_hit,
  output logic [OFFSET_W-1:0] rom_offset,
  output logic [BYTE_W-1:0]   patch_byte
);

  ccram_cfg_t    cfg;
  ccram_result_t decoded;
  ccram_result_t result;

  logic              code_reg_valid;
  logic [CODE_W-1:0] code_reg;
  logic              advance_result;
  logic              advance_code;

  ccram_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the result register when it is empty or being taken; advance the
  // input register when it is empty or moving on into the result register.
  assign advance_result = !result_valid || !result_stall;
  assign advance_code   = !code_reg_valid || advance_result;
  assign code_stall     = !advance_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_reg_valid <= 1'b0;
    end else if (advance_code) begin
      code_reg_valid <= code_valid;
    end
  end

  // payload: hold while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (advance_code && code_valid) begin
      code_reg <= code;
    end
  end

  ccram_decode u_decode (
    .code   (code_reg),
    .cfg    (cfg),
    .result (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance_result) begin
      result_valid <= code_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_result && code_reg_valid) begin
      result <= decoded;
    end
  end

  assign is_wram    = result.is_wram;
  assign rom_hit    = result.rom_hit;
  assign rom_offset = result.rom_offset;
  assign patch_byte = result.patch_byte;

`ifndef ASSERT_OFF
  // input stalls only when both stages are full and the output is stalled
  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (rst)
    code_stall |-> (code_reg_valid && result_valid && result_stall)
  ) else $error("input stalled with room in the pipeline");

  // a work RAM code never carries a ROM hit or offset
  a_wram_no_rom: assert property (
    @(posedge clk) disable iff (rst)
    (result_valid && is_wram) |-> (!rom_hit && (rom_offset == '0))
  ) else $error("work RAM code reported a ROM hit or offset");

  // a miss gives a zero offset
  a_miss_zero_offset: assert property (
    @(posedge clk) disable iff (rst)
    (result_valid && !rom_hit) |-> (rom_offset == '0)
  ) else $error("ROM miss with nonzero offset");

  // a decoded code held in the input stage moves on once the output frees up
  a_stage_moves: assert property (
    @(posedge clk) disable iff (rst)
    (code_reg_valid && !result_valid) |=> result_valid
  ) else $error("decoded code did not reach the result register");
`endif

endmodule
